/* rtl/mp4btw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the MP4 box tree walker.
// No dependencies.
package mp4btw_pkg;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LOAD,
    S_EXEC
  } state_t;

  // Error codes reported with the final item
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIZE      = 3'd1;
  localparam logic [2:0] ERR_PARENT    = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_DEPTH     = 3'd4;

  // Header geometry
  localparam logic [2:0]  HDR_LAST_BYTE = 3'd7;
  localparam logic [31:0] MIN_BOX_SIZE  = 32'd8;

  // Container fourccs: these boxes are entered and their children walked
  localparam logic [31:0] FCC_MOOV = 32'h6D6F6F76;
  localparam logic [31:0] FCC_TRAK = 32'h7472616B;
  localparam logic [31:0] FCC_MOOF = 32'h6D6F6F66;
  localparam logic [31:0] FCC_TRAF = 32'h74726166;
  localparam logic [31:0] FCC_ILST = 32'h696C7374;
  localparam logic [31:0] FCC_META = 32'h6D657461;
  localparam logic [31:0] FCC_MVEX = 32'h6D766578;
  localparam logic [31:0] FCC_MDIA = 32'h6D646961;
  localparam logic [31:0] FCC_MINF = 32'h6D696E66;
  localparam logic [31:0] FCC_STBL = 32'h7374626C;
  localparam logic [31:0] FCC_DREF = 32'h64726566;
  localparam logic [31:0] FCC_DTOO = 32'h2E746F6F;

  function automatic logic is_container_type(input logic [31:0] fcc);
    logic hit;
    case (fcc)
      FCC_MOOV, FCC_TRAK, FCC_MOOF, FCC_TRAF, FCC_ILST, FCC_META,
      FCC_MVEX, FCC_MDIA, FCC_MINF, FCC_STBL, FCC_DREF, FCC_DTOO: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage
`default_nettype wire

/* rtl/mp4btw_end_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// Stack memory of open container end positions.
// One write port, one read port with registered read data; no package use.
module mp4btw_end_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/mp4_box_tree_walker.sv */
`timescale 1ns / 1ps
`default_nettype none
// MP4 box tree walker: one file byte per input item, one result item per accepted
// box header and on the last byte. A byte is worked in the cycle it is taken unless
// a container closes or a result waits, its result valid the next cycle: one byte
// per cycle while results drain and no container closes. Each closed level takes a
// pop step plus an end memory read unless the stack empties; a waiting result holds
// the byte in S_EXEC. Reset: synchronous; end memory not cleared (read if pushed).
module mp4_box_tree_walker
  import mp4btw_pkg::*;
#(
  parameter int MAX_DEPTH     = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // is_last
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] box_type, [63:32] box_size, [67:64] nest_depth,
  // [68] is_container, [71:69] error_code
  output      logic [71:0] m_axis_tdata,
  output      logic        m_axis_tuser,   // has_box
  output      logic        m_axis_tlast    // done_res
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);
  localparam int PB = POSITION_BITS;

  state_t state, state_next;

  logic [PB-1:0] pos, pos_next;
  logic [PB-1:0] skip_end, skip_end_next;
  logic [PB-1:0] top_end, top_end_next;
  logic [LW-1:0] open_levels, open_levels_next;
  logic [55:0]   hdr_shift, hdr_shift_next;
  logic [2:0]    hdr_cnt, hdr_cnt_next;
  logic [2:0]    sticky_err, sticky_err_next;
  logic [7:0]    held_byte;
  logic          held_last;

  // stack memory ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PB-1:0] ram_wdata, ram_rdata;

  // result register inputs
  logic          emit;
  logic          o_box, o_cont, o_done;
  logic [31:0]   o_type, o_size;
  logic [3:0]    o_depth;
  logic [2:0]    o_err;

  // datapath for the byte being worked
  logic          out_free, pop_need, parsing;
  logic [7:0]    cur_byte;
  logic          cur_last;
  logic [63:0]   hdr_word;
  logic [31:0]   hdr_size, hdr_type;
  logic [PB-1:0] box_start, box_end;
  logic          hdr_cont;
  logic [LW-1:0] levels_dec;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cur_byte  = (state == S_IDLE) ? s_axis_tdata : held_byte;
  assign cur_last  = (state == S_IDLE) ? s_axis_tlast : held_last;
  assign parsing   = (sticky_err == ERR_NONE) && (pos >= skip_end);
  assign pop_need  = parsing && (hdr_cnt == 3'd0) && (open_levels != '0) &&
                     (top_end <= pos);
  assign levels_dec = open_levels - LW'(1);

  // header decode on the eighth byte
  assign hdr_word  = {hdr_shift, cur_byte};
  assign hdr_size  = hdr_word[63:32];
  assign hdr_type  = hdr_word[31:0];
  assign box_start = pos - PB'(7);
  assign box_end   = box_start + PB'(hdr_size);
  assign hdr_cont  = is_container_type(hdr_type);

  assign s_axis_tready = (state == S_IDLE);

  mp4btw_end_ram #(
    .DEPTH (MAX_DEPTH),
    .WIDTH (PB)
  ) u_end_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer and byte processing
  always_comb begin
    logic do_exec;
    logic box;
    logic [2:0] err_fin;
    state_next       = state;
    pos_next         = pos;
    skip_end_next    = skip_end;
    top_end_next     = top_end;
    open_levels_next = open_levels;
    hdr_shift_next   = hdr_shift;
    hdr_cnt_next     = hdr_cnt;
    sticky_err_next  = sticky_err;
    ram_we           = 1'b0;
    ram_waddr        = open_levels[AW-1:0];
    ram_wdata        = box_end;
    ram_re           = 1'b0;
    ram_raddr        = '0;
    do_exec          = 1'b0;
    box              = 1'b0;
    err_fin          = ERR_NONE;
    emit             = 1'b0;
    o_box            = 1'b0;
    o_type           = '0;
    o_size           = '0;
    o_depth          = '0;
    o_cont           = 1'b0;
    o_done           = 1'b0;
    o_err            = ERR_NONE;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (pop_need) begin
            state_next = S_POP;
          end else if (!out_free) begin
            state_next = S_EXEC;
          end else begin
            do_exec = 1'b1;
          end
        end
      end
      S_POP: begin
        if (pop_need) begin
          open_levels_next = levels_dec;
          if (levels_dec != '0) begin
            ram_re     = 1'b1;
            ram_raddr  = AW'(open_levels - LW'(2));
            state_next = S_LOAD;
          end else begin
            state_next = S_EXEC;
          end
        end else begin
          state_next = S_EXEC;
        end
      end
      S_LOAD: begin
        top_end_next = ram_rdata;
        state_next   = S_POP;
      end
      S_EXEC: begin
        if (out_free) begin
          do_exec    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (do_exec) begin
      // shift the byte into the header, check the box once complete
      if (parsing) begin
        if (hdr_cnt == HDR_LAST_BYTE) begin
          hdr_cnt_next   = 3'd0;
          hdr_shift_next = '0;
          if (hdr_size < MIN_BOX_SIZE) begin
            sticky_err_next = ERR_SIZE;
          end else if ((box_end < box_start) ||
                       ((open_levels != '0) && (box_end > top_end))) begin
            sticky_err_next = ERR_PARENT;
          end else if (hdr_cont && (open_levels >= LW'(MAX_DEPTH))) begin
            sticky_err_next = ERR_DEPTH;
          end else begin
            box = 1'b1;
            if (hdr_cont) begin
              ram_we           = 1'b1;
              top_end_next     = box_end;
              open_levels_next = open_levels + LW'(1);
            end else begin
              skip_end_next = box_end;
            end
          end
        end else begin
          hdr_cnt_next   = hdr_cnt + 3'd1;
          hdr_shift_next = hdr_word[55:0];
        end
      end
      pos_next = pos + PB'(1);

      // final byte: report sticky or truncation error, then start over
      if (cur_last) begin
        err_fin = sticky_err_next;
        if (sticky_err_next == ERR_NONE && hdr_cnt_next != 3'd0) begin
          err_fin = ERR_TRUNCATED;
        end
        pos_next         = '0;
        skip_end_next    = '0;
        open_levels_next = '0;
        hdr_shift_next   = '0;
        hdr_cnt_next     = 3'd0;
        sticky_err_next  = ERR_NONE;
      end

      emit   = box || cur_last;
      o_box  = box;
      o_done = cur_last;
      o_err  = err_fin;
      if (box) begin
        o_type  = hdr_type;
        o_size  = hdr_size;
        o_depth = (32'(open_levels) > 32'd15) ? 4'd15 : 4'(open_levels);
        o_cont  = hdr_cont;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      skip_end    <= '0;
      open_levels <= '0;
      hdr_shift   <= '0;
      hdr_cnt     <= 3'd0;
      sticky_err  <= ERR_NONE;
    end else begin
      state       <= state_next;
      pos         <= pos_next;
      skip_end    <= skip_end_next;
      open_levels <= open_levels_next;
      hdr_shift   <= hdr_shift_next;
      hdr_cnt     <= hdr_cnt_next;
      sticky_err  <= sticky_err_next;
    end
  end

  // cached top of stack and held input byte
  always_ff @(posedge clk) begin
    top_end <= top_end_next;
    if (s_axis_tvalid && s_axis_tready) begin
      held_byte <= s_axis_tdata;
      held_last <= s_axis_tlast;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {o_err, o_cont, o_depth, o_size, o_type};
      m_axis_tuser <= o_box;
      m_axis_tlast <= o_done;
    end
  end

  // stack never holds more than its depth
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    open_levels <= LW'(MAX_DEPTH))
    else $error("open level count past stack depth");

  // every result is a box or the end of file
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
    else $error("result with neither box nor done");

  // error codes appear only on the final item
  a_err_on_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[71:69] == ERR_NONE))
    else $error("error code on a non-final item");

  // each pop step removes exactly one level
  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP && pop_need) |=> (open_levels == $past(levels_dec)))
    else $error("pop did not remove one level");

  // a memory read is always followed by loading the new top
  a_load_follows: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (state == S_LOAD))
    else $error("stack read without top reload");

endmodule
`default_nettype wire
